>>> rtl/cell_range_reference_parser_top_defines.svh
// assertion macros for the checker file rcp_checker.sv
`ifndef CELL_RANGE_REFERENCE_PARSER_TOP_DEFINES_SVH
`define CELL_RANGE_REFERENCE_PARSER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define RCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define RCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rcp_pkg.sv
`timescale 1ns / 1ps

package rcp_pkg;

  localparam int COL_W      = 15;
  localparam int ROW_W      = 21;
  localparam int CFG_W      = 21;
  localparam int CFG_IDX_W  = 1;
  localparam int COL_MUL_W  = 20;  // 15-bit column * 26 + 26
  localparam int ROW_MUL_W  = 25;  // 21-bit row * 10 + 9

  localparam logic [COL_W-1:0] COL_LIMIT_RESET = 15'd16384;
  localparam logic [ROW_W-1:0] ROW_LIMIT_RESET = 21'd1048576;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LIMIT    = 1'd1;

  // character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_Z      = 8'h5A;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;

  localparam logic [COL_MUL_W-1:0] COL_RADIX = 20'd26;
  localparam logic [ROW_MUL_W-1:0] ROW_RADIX = 25'd10;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic             ref_valid;
    logic [COL_W-1:0] left_col;
    logic [ROW_W-1:0] top_row;
    logic [COL_W-1:0] right_col;
    logic [ROW_W-1:0] bottom_row;
  } out_t;

  // limits handed from the config registers to the parser
  typedef struct packed {
    logic [COL_W-1:0] column_limit;
    logic [ROW_W-1:0] row_limit;
  } limits_t;

endpackage

>>> rtl/rcp_in_reg.sv
`timescale 1ns / 1ps

module rcp_in_reg (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  rcp_pkg::in_t in_data,
  input  logic         take,
  output logic         hold_valid,
  output rcp_pkg::in_t hold_data
);

  // free when empty or when the held beat leaves this cycle
  assign in_ready = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_data <= in_data;
    end
  end

endmodule

>>> rtl/rcp_parse.sv
`timescale 1ns / 1ps

module rcp_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  rcp_pkg::in_t     item,
  input  rcp_pkg::limits_t limits,
  output rcp_pkg::out_t    result
);

  logic                          error_seen;
  logic                          in_second_part;
  logic                          digits_started;
  logic [rcp_pkg::COL_W-1:0]     first_column;
  logic [rcp_pkg::ROW_W-1:0]     first_row;
  logic [rcp_pkg::COL_W-1:0]     second_column;
  logic [rcp_pkg::ROW_W-1:0]     second_row;

  logic                          error_seen_next;
  logic                          in_second_part_next;
  logic                          digits_started_next;
  logic [rcp_pkg::COL_W-1:0]     first_column_next;
  logic [rcp_pkg::ROW_W-1:0]     first_row_next;
  logic [rcp_pkg::COL_W-1:0]     second_column_next;
  logic [rcp_pkg::ROW_W-1:0]     second_row_next;

  logic [7:0]                    ch;
  logic                          is_letter;
  logic                          is_digit;
  logic [4:0]                    letter_val;
  logic [3:0]                    digit_val;
  logic [rcp_pkg::COL_W-1:0]     col_sel;
  logic [rcp_pkg::ROW_W-1:0]     row_sel;
  logic [rcp_pkg::COL_MUL_W-1:0] col_grow;
  logic [rcp_pkg::ROW_MUL_W-1:0] row_grow;
  logic                          col_write;
  logic                          row_write;
  logic                          cols_all, cols_none, rows_all, rows_none;
  logic                          ok;

  assign ch         = item.char_code;
  assign is_letter  = (ch >= rcp_pkg::CH_A) && (ch <= rcp_pkg::CH_Z);
  assign is_digit   = (ch >= rcp_pkg::CH_0) && (ch <= rcp_pkg::CH_9);
  assign letter_val = 5'(ch - rcp_pkg::CH_A) + 5'd1;
  assign digit_val  = 4'(ch - rcp_pkg::CH_0);
  assign col_sel    = in_second_part ? second_column : first_column;
  assign row_sel    = in_second_part ? second_row : first_row;
  assign col_grow   = rcp_pkg::COL_MUL_W'(col_sel) * rcp_pkg::COL_RADIX
                    + rcp_pkg::COL_MUL_W'(letter_val);
  assign row_grow   = rcp_pkg::ROW_MUL_W'(row_sel) * rcp_pkg::ROW_RADIX
                    + rcp_pkg::ROW_MUL_W'(digit_val);

  // one character against the current part
  always_comb begin
    error_seen_next     = error_seen;
    in_second_part_next = in_second_part;
    digits_started_next = digits_started;
    col_write           = 1'b0;
    row_write           = 1'b0;
    if (!error_seen) begin
      priority if (ch == rcp_pkg::CH_DOLLAR) begin
        // absolute marks carry no meaning here
      end else if (ch == rcp_pkg::CH_COLON) begin
        if (in_second_part) begin
          error_seen_next = 1'b1;
        end else begin
          in_second_part_next = 1'b1;
          digits_started_next = 1'b0;
        end
      end else if (is_letter) begin
        if (digits_started) begin
          error_seen_next = 1'b1;
        end else if (col_grow > rcp_pkg::COL_MUL_W'(limits.column_limit)) begin
          error_seen_next = 1'b1;
        end else begin
          col_write = 1'b1;
        end
      end else if (is_digit) begin
        digits_started_next = 1'b1;
        if (row_sel == '0 && ch == rcp_pkg::CH_0) begin
          error_seen_next = 1'b1;
        end else if (row_grow > rcp_pkg::ROW_MUL_W'(limits.row_limit)) begin
          error_seen_next = 1'b1;
        end else begin
          row_write = 1'b1;
        end
      end else begin
        error_seen_next = 1'b1;
      end
    end
  end

  always_comb begin
    first_column_next  = first_column;
    second_column_next = second_column;
    first_row_next     = first_row;
    second_row_next    = second_row;
    if (col_write) begin
      if (in_second_part) begin
        second_column_next = col_grow[rcp_pkg::COL_W-1:0];
      end else begin
        first_column_next = col_grow[rcp_pkg::COL_W-1:0];
      end
    end
    if (row_write) begin
      if (in_second_part) begin
        second_row_next = row_grow[rcp_pkg::ROW_W-1:0];
      end else begin
        first_row_next = row_grow[rcp_pkg::ROW_W-1:0];
      end
    end
  end

  // whole-expression check on the updated state
  assign cols_all  = (first_column_next != '0) && (second_column_next != '0);
  assign cols_none = (first_column_next == '0) && (second_column_next == '0);
  assign rows_all  = (first_row_next != '0) && (second_row_next != '0);
  assign rows_none = (first_row_next == '0) && (second_row_next == '0);

  always_comb begin
    priority if (error_seen_next) begin
      ok = 1'b0;
    end else if (!in_second_part_next) begin
      ok = (first_column_next != '0) && (first_row_next != '0);
    end else begin
      ok = (cols_all || cols_none) && (rows_all || rows_none)
        && !(cols_none && rows_none)
        && !(cols_all && (second_column_next < first_column_next))
        && !(rows_all && (second_row_next < first_row_next));
    end
  end

  always_comb begin
    result = '0;
    if (ok) begin
      result.ref_valid  = 1'b1;
      result.left_col   = first_column_next;
      result.top_row    = first_row_next;
      result.right_col  = in_second_part_next ? second_column_next : first_column_next;
      result.bottom_row = in_second_part_next ? second_row_next : first_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_char)) begin
      error_seen     <= 1'b0;
      in_second_part <= 1'b0;
      digits_started <= 1'b0;
      first_column   <= '0;
      first_row      <= '0;
      second_column  <= '0;
      second_row     <= '0;
    end else if (step) begin
      error_seen     <= error_seen_next;
      in_second_part <= in_second_part_next;
      digits_started <= digits_started_next;
      first_column   <= first_column_next;
      first_row      <= first_row_next;
      second_column  <= second_column_next;
      second_row     <= second_row_next;
    end
  end

endmodule

>>> rtl/rcp_out_reg.sv
`timescale 1ns / 1ps

module rcp_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  rcp_pkg::out_t load_data,
  output logic          slot_free,
  output logic          out_valid,
  input  logic          out_ready,
  output rcp_pkg::out_t out_data
);

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && slot_free) begin
      out_data <= load_data;
    end
  end

endmodule

>>> rtl/cell_range_reference_parser_top.sv
`timescale 1ns / 1ps
// a1-style cell range reference parser (A1, $B$2:C9, A:C, 3:7)
// input channel: one character beat per item on in_valid/in_ready, with
//   last_char set on the final character of an expression
// output channel: one result beat per expression on out_valid/out_ready,
//   carrying ref_valid and the four bounds (all zero when not valid)
// config port: cfg_write with cfg_index 0 sets column_limit, 1 sets row_limit;
//   write only while no expression is in flight
// throughput: one character per cycle, except that a final character waits while
//   a result sits in the output register; the column/row accumulators update
//   combinationally (times 26 or times 10, add, compare); a final character
//   passes the input register, then is parsed into the output register
// stall: while a result waits in the output register, non-final characters
//   keep flowing; a final character waits in the input register until the
//   output register frees up, and in_ready drops behind it
// reset: rst is synchronous; it empties both registers, clears the parse state
//   and sets the limits to 16384 columns and 1048576 rows

module cell_range_reference_parser_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rcp_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rcp_pkg::out_t                   out_data,
  input  logic                            cfg_write,
  input  logic [rcp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcp_pkg::CFG_W-1:0]       cfg_data
);

  rcp_pkg::limits_t limits;
  rcp_pkg::in_t     hold_data;
  rcp_pkg::out_t    result;
  logic             hold_valid;
  logic             slot_free;
  logic             step;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.column_limit <= rcp_pkg::COL_LIMIT_RESET;
      limits.row_limit    <= rcp_pkg::ROW_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rcp_pkg::REG_COLUMN_LIMIT: limits.column_limit <= cfg_data[rcp_pkg::COL_W-1:0];
        rcp_pkg::REG_ROW_LIMIT:    limits.row_limit    <= cfg_data[rcp_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // a held character moves on unless it is final and the result slot is busy
  assign step = hold_valid && (!hold_data.last_char || slot_free);

  rcp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (step),
    .hold_valid (hold_valid),
    .hold_data  (hold_data)
  );

  rcp_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (hold_data),
    .limits (limits),
    .result (result)
  );

  // only the final character of an expression produces a beat
  rcp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (step && hold_data.last_char),
    .load_data (result),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> rtl/rcp_checker.sv
`timescale 1ns / 1ps
`include "cell_range_reference_parser_top_defines.svh"

module rcp_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input rcp_pkg::out_t out_data
);

  logic bounds_zero;
  logic bounds_ordered;

  assign bounds_zero    = (out_data.left_col == '0) && (out_data.top_row == '0)
                       && (out_data.right_col == '0) && (out_data.bottom_row == '0);
  assign bounds_ordered = (out_data.right_col >= out_data.left_col)
                       && (out_data.bottom_row >= out_data.top_row);

  `RCP_ASSERT_NOW(a_invalid_zero, out_valid && !out_data.ref_valid, bounds_zero, "invalid result with nonzero bounds")
  `RCP_ASSERT_NOW(a_bounds_order, out_valid && out_data.ref_valid, bounds_ordered, "result bounds out of order")
  `RCP_ASSERT_NOW(a_empty_after_reset, $past(rst), !out_valid, "result beat right after reset")
  `RCP_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result beat changed")

endmodule

bind cell_range_reference_parser_top rcp_checker u_rcp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/ref_parse_checker.sv
`timescale 1ns / 1ps

module ref_parse_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  rcp_pkg::in_t                  in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  rcp_pkg::out_t                 out_data,
  input  logic                          cfg_write,
  input  logic [rcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcp_pkg::CFG_W-1:0]     cfg_data,
  output int                            mismatches,
  output int                            pending
);

  import rcp_pkg::*;

  logic [COL_W-1:0] column_limit;
  logic [ROW_W-1:0] row_limit;

  // parse state of the expression in flight
  logic             failed_expr;
  logic             past_colon;
  logic             row_digits;
  logic [COL_W-1:0] col_lo;
  logic [ROW_W-1:0] row_lo;
  logic [COL_W-1:0] col_hi;
  logic [ROW_W-1:0] row_hi;

  out_t expected_refs[$];
  out_t want;

  task automatic clear_expression_state();
    failed_expr = 1'b0;
    past_colon  = 1'b0;
    row_digits  = 1'b0;
    col_lo      = '0;
    row_lo      = '0;
    col_hi      = '0;
    row_hi      = '0;
  endtask

  task automatic absorb_char(input logic [7:0] c);
    logic        second;
    int unsigned col;
    int unsigned row;
    int unsigned nxt;
    second = past_colon;
    col    = second ? col_hi : col_lo;
    row    = second ? row_hi : row_lo;
    if (c == CH_DOLLAR) begin
      // absolute marker, no effect
    end else if (c == CH_COLON) begin
      if (past_colon) begin
        failed_expr = 1'b1;
      end else begin
        past_colon = 1'b1;
        row_digits = 1'b0;
      end
    end else if (c >= CH_A && c <= CH_Z) begin
      nxt = col * COL_RADIX + (c - CH_A + 1);
      if (row_digits || nxt > column_limit) failed_expr = 1'b1;
      else col = nxt;
    end else if (c >= CH_0 && c <= CH_9) begin
      row_digits = 1'b1;
      nxt = row * ROW_RADIX + (c - CH_0);
      if ((row == 0 && c == CH_0) || nxt > row_limit) failed_expr = 1'b1;
      else row = nxt;
    end else begin
      failed_expr = 1'b1;
    end
    if (second) begin
      col_hi = COL_W'(col);
      row_hi = ROW_W'(row);
    end else begin
      col_lo = COL_W'(col);
      row_lo = ROW_W'(row);
    end
  endtask

  function automatic out_t reference_result();
    logic cols_all;
    logic cols_none;
    logic rows_all;
    logic rows_none;
    logic ok;
    out_t r;
    cols_all  = col_lo != 0 && col_hi != 0;
    cols_none = col_lo == 0 && col_hi == 0;
    rows_all  = row_lo != 0 && row_hi != 0;
    rows_none = row_lo == 0 && row_hi == 0;
    if (failed_expr) ok = 1'b0;
    else if (!past_colon) ok = col_lo != 0 && row_lo != 0;
    else ok = (cols_all || cols_none) && (rows_all || rows_none) &&
              !(cols_none && rows_none) &&
              !(cols_all && col_hi < col_lo) && !(rows_all && row_hi < row_lo);
    r = '0;
    if (ok) begin
      r.ref_valid  = 1'b1;
      r.left_col   = col_lo;
      r.top_row    = row_lo;
      r.right_col  = past_colon ? col_hi : col_lo;
      r.bottom_row = past_colon ? row_hi : row_lo;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      column_limit = COL_LIMIT_RESET;
      row_limit    = ROW_LIMIT_RESET;
      clear_expression_state();
      expected_refs.delete();
      mismatches = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_COLUMN_LIMIT) column_limit = cfg_data[COL_W-1:0];
        else if (cfg_index == REG_ROW_LIMIT) row_limit = cfg_data[ROW_W-1:0];
      end
      if (in_valid && in_ready) begin
        if (!failed_expr) absorb_char(in_data.char_code);
        if (in_data.last_char) begin
          expected_refs.push_back(reference_result());
          clear_expression_state();
        end
      end
      if (out_valid && out_ready) begin
        if (expected_refs.size() == 0) begin
          $error("result beat with no expression pending");
          mismatches++;
        end else begin
          want = expected_refs.pop_front();
          check_field("ref_valid", want.ref_valid, out_data.ref_valid);
          check_field("left_col", want.left_col, out_data.left_col);
          check_field("top_row", want.top_row, out_data.top_row);
          check_field("right_col", want.right_col, out_data.right_col);
          check_field("bottom_row", want.bottom_row, out_data.bottom_row);
        end
      end
    end
    pending = expected_refs.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import rcp_pkg::*;

  // run length guard, far above the slowest legal run
  localparam int CYCLE_LIMIT    = 200000;
  // long output hold-off that backs the parser up into its input
  localparam int HOLD_CYCLES    = 300;
  // parser settle time before a cfg write, once every result is back
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_CHARS    = 115;
  localparam int NUM_PHASES     = 7;
  localparam int PRESSURE_PHASE = 6;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_COLUMN_LIMIT;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int mismatches;
  int pending;

  // idle rates for the current phase, in percent per cycle
  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_req      = 1'b0;

  // limits in force, so the generator can aim right at the edges
  int unsigned cur_col_lim = COL_LIMIT_RESET;
  int unsigned cur_row_lim = ROW_LIMIT_RESET;

  int         chars_sent  = 0;
  int         cycle_count = 0;
  logic [7:0] expr_chars[$];

  // per phase: column limit, row limit, sender idle, receiver stall
  // extremes: minimum limits, zero limits (reject every column letter or every row digit), reset maximums
  int unsigned phase_cols[NUM_PHASES]  = '{16384, 1, 28, 0, 16384, 703, 16384};
  int unsigned phase_rows[NUM_PHASES]  = '{1048576, 1, 500, 1048576, 0, 120, 1048576};
  int          phase_idle[NUM_PHASES]  = '{0, 71, 0, 25, 0, 25, 0};
  int          phase_stall[NUM_PHASES] = '{0, 0, 71, 25, 0, 25, 0};

  // hand-picked expressions: plain cell, absolute range, column range,
  // row range, letter after digits, leading zero, bare colon, lower case,
  // range with the second bound below the first
  string directed_refs[9] = '{"A1", "$B$2:C9", "A:C", "3:7", "1A", "0", ":", "b1",
                              "B1:A1"};

  cell_range_reference_parser_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ref_parse_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // both limits back to back, write enable held across the two beats
  task automatic set_limits(input int unsigned col_lim, input int unsigned row_lim);
    cfg_write <= 1'b1;
    cfg_index <= REG_COLUMN_LIMIT;
    cfg_data  <= CFG_W'(col_lim);
    @(negedge clk);
    cfg_index <= REG_ROW_LIMIT;
    cfg_data  <= CFG_W'(row_lim);
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_col_lim = col_lim;
    cur_row_lim = row_lim;
    @(negedge clk);
  endtask

  // push the queued characters out, one beat each, last flag on the final one
  task automatic send_expression();
    in_t beat;
    foreach (expr_chars[i]) begin
      beat.char_code = expr_chars[i];
      beat.last_char = (i == expr_chars.size() - 1);
      // random gap before the beat, valid low while idle
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= beat;
      do @(posedge clk); while (!in_ready);
      @(negedge clk);
    end
    chars_sent += expr_chars.size();
    expr_chars.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
  endtask

  task automatic maybe_dollar();
    if ($urandom_range(0, 99) < 30) expr_chars.push_back(CH_DOLLAR);
  endtask

  // column number to letters, bijective base 26 (1 = A, 27 = AA)
  task automatic push_column(input int unsigned n);
    logic [7:0] letters[$];
    while (n > 0) begin
      n--;
      letters.push_front(CH_A + 8'(n % COL_RADIX));
      n /= COL_RADIX;
    end
    foreach (letters[i]) expr_chars.push_back(letters[i]);
  endtask

  task automatic push_row(input int unsigned n);
    logic [7:0] digits[$];
    while (n > 0) begin
      digits.push_front(CH_0 + 8'(n % ROW_RADIX));
      n /= ROW_RADIX;
    end
    foreach (digits[i]) expr_chars.push_back(digits[i]);
  endtask

  task automatic put_cell(input int unsigned col, input int unsigned row);
    maybe_dollar();
    push_column(col);
    maybe_dollar();
    push_row(row);
  endtask

  // bound for the generator: mostly legal and small, often right at the
  // limit, sometimes one past it
  function automatic int unsigned pick_bound(input int unsigned limit);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (limit == 0) return $urandom_range(1, 30);
    if (roll < 10) return limit;
    if (roll < 18) return limit + 1;
    if (roll < 60) return $urandom_range(1, (limit < 30) ? limit : 30);
    return $urandom_range(1, limit);
  endfunction

  task automatic compose_expression();
    int unsigned roll;
    int unsigned c1, r1, c2, r2, t;
    string       noise_set;
    noise_set = "$:AZ09az";
    roll = $urandom_range(0, 99);
    c1 = pick_bound(cur_col_lim);
    r1 = pick_bound(cur_row_lim);
    c2 = pick_bound(cur_col_lim);
    r2 = pick_bound(cur_row_lim);
    // ranges are mostly ordered, the rest exercise the ordering check
    if ($urandom_range(0, 3) != 0) begin
      if (c2 < c1) begin
        t = c1; c1 = c2; c2 = t;
      end
      if (r2 < r1) begin
        t = r1; r1 = r2; r2 = t;
      end
    end
    if (roll < 35) begin
      put_cell(c1, r1);
    end else if (roll < 58) begin
      put_cell(c1, r1);
      expr_chars.push_back(CH_COLON);
      put_cell(c2, r2);
    end else if (roll < 66) begin
      maybe_dollar();
      push_column(c1);
      expr_chars.push_back(CH_COLON);
      maybe_dollar();
      push_column(c2);
    end else if (roll < 74) begin
      maybe_dollar();
      push_row(r1);
      expr_chars.push_back(CH_COLON);
      maybe_dollar();
      push_row(r2);
    end else if (roll < 88) begin
      // near misses of a well-formed reference
      case ($urandom_range(0, 7))
        0: begin
          expr_chars.push_back(CH_LOWER_A + 8'($urandom_range(0, 25)));
          push_row(r1);
        end
        1: begin
          push_column(c1);
          expr_chars.push_back(CH_0);
          push_row(r1);
        end
        2: begin
          put_cell(c1, r1);
          push_column(c2);
        end
        3: begin
          put_cell(c1, r1);
          push_text("::");
          put_cell(c2, r2);
        end
        4: begin
          put_cell(c1, r1);
          expr_chars.push_back(CH_COLON);
          push_column(c2);
        end
        5: begin
          if ($urandom_range(0, 1)) push_column(c1);
          else push_row(r1);
        end
        6: begin
          maybe_dollar();
          expr_chars.push_back(CH_COLON);
          maybe_dollar();
        end
        default: begin
          put_cell(c1, r1);
          expr_chars.insert($urandom_range(0, expr_chars.size()),
                            8'($urandom_range(0, 255)));
        end
      endcase
    end else begin
      // raw noise, half of it from a small set near the parser's own alphabet
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 1))
          expr_chars.push_back(noise_set[$urandom_range(0, noise_set.len() - 1)]);
        else
          expr_chars.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int start_count;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      // sender pauses until every result is back, then the parser settles
      while (pending != 0) @(negedge clk);
      repeat (SETTLE_CYCLES) @(negedge clk);
      set_limits(phase_cols[p], phase_rows[p]);
      send_idle_pct = phase_idle[p];
      stall_pct     = phase_stall[p];
      if (p == 0) begin
        foreach (directed_refs[i]) begin
          push_text(directed_refs[i]);
          send_expression();
        end
      end
      // receiver holds off while characters keep coming, so a final
      // character parks in the input register and in_ready drops
      if (p == PRESSURE_PHASE) hold_req = 1'b1;
      start_count = chars_sent;
      while (chars_sent - start_count < PHASE_CHARS) begin
        compose_expression();
        send_expression();
      end
      in_valid <= 1'b0;
    end
    while (pending != 0) @(negedge clk);
    // catch any stray result beat after the last expected one
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
